>>> rtl/wtt_pkg.sv
package wtt_pkg;

  localparam logic [1:0] CMD_REGISTER   = 2'd0;
  localparam logic [1:0] CMD_UNREGISTER = 2'd1;
  localparam logic [1:0] CMD_TICK       = 2'd2;

  localparam logic [2:0] KIND_REG       = 3'd0;
  localparam logic [2:0] KIND_REG_ERR   = 3'd1;
  localparam logic [2:0] KIND_UNREG     = 3'd2;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [2:0] KIND_FIRED     = 3'd4;
  localparam logic [2:0] KIND_DONE      = 3'd5;

  typedef struct packed {
    logic do_reg;
    logic do_unreg;
    logic do_tick;
    logic scan_rd;
    logic scan_skip;
    logic fire_emit;
    logic done_emit;
  } wtt_ctl_t;

  typedef struct packed {
    logic out_free;
    logic scan_end;
    logic scan_act;
    logic scan_hit;
  } wtt_sts_t;

endpackage

>>> rtl/watchdog_timer_table_core.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid_i/in_stall_o  command_i, slot_i, interval_i, one_shot_i
// out      output     out_valid_o/out_stall_i kind_o, event_slot_o, time_now_o, last_o
//
// Register and unregister commands are handled in the idle state without leaving it.
// A tick is accepted in the idle state; the scan then skips each inactive slot in
// the read state, reads each active slot from the slot table memory and evaluates
// it in the eval state, detects the end of the table and gives the done result.
// Reset clears the time counter and all slot state; the slot memory needs no clearing.
// A stalled output holds its result, and a new transfer waits until the output frees.
module watchdog_timer_table_core #(
  parameter int SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] interval_i,
  input  logic        one_shot_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [3:0]  event_slot_o,
  output logic [31:0] time_now_o,
  output logic        last_o
);
  import wtt_pkg::*;

  wtt_ctl_t ctl;
  wtt_sts_t sts;

  wtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .ctl_o      (ctl)
  );

  wtt_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .slot_i       (slot_i),
    .interval_i   (interval_i),
    .one_shot_i   (one_shot_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .kind_o       (kind_o),
    .event_slot_o (event_slot_o),
    .time_now_o   (time_now_o),
    .last_o       (last_o)
  );

endmodule

>>> rtl/wtt_ram.sv
module wtt_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/wtt_ctrl.sv
module wtt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      command_i,
  input  wtt_pkg::wtt_sts_t sts_i,
  output logic            in_stall_o,
  output wtt_pkg::wtt_ctl_t ctl_o
);
  import wtt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = !sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          case (command_i)
            CMD_REGISTER:   ctl_o.do_reg = 1'b1;
            CMD_UNREGISTER: ctl_o.do_unreg = 1'b1;
            CMD_TICK: begin
              ctl_o.do_tick = 1'b1;
              state_d       = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (sts_i.scan_end) begin
          state_d = S_DONE;
        end else if (sts_i.scan_act) begin
          ctl_o.scan_rd = 1'b1;
          state_d       = S_EVAL;
        end else begin
          ctl_o.scan_skip = 1'b1;
        end
      end
      S_EVAL: begin
        if (!sts_i.scan_hit) begin
          ctl_o.scan_skip = 1'b1;
          state_d         = S_READ;
        end else if (sts_i.out_free) begin
          ctl_o.fire_emit = 1'b1;
          state_d         = S_READ;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.done_emit = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/wtt_datapath.sv
module wtt_datapath #(
  parameter int SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wtt_pkg::wtt_ctl_t ctl_i,
  output wtt_pkg::wtt_sts_t sts_o,
  input  logic [3:0]        slot_i,
  input  logic [31:0]       interval_i,
  input  logic              one_shot_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [2:0]        kind_o,
  output logic [3:0]        event_slot_o,
  output logic [31:0]       time_now_o,
  output logic              last_o
);
  import wtt_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int RW = 65;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  logic [31:0]    time_q, time_d;
  logic [SLOTS-1:0] act_q, act_d, inact_q, inact_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [SW-1:0]  idx_s, in_idx;
  logic           slot_ok, reg_err, found;
  logic           ram_we;
  logic [SW-1:0]  ram_waddr;
  logic [RW-1:0]  ram_wdata, ram_rdata;
  logic           rd_os;
  logic [31:0]    rd_ivl, rd_dl;
  logic           out_valid_q, out_valid_d;
  logic [2:0]     kind_q, kind_d;
  logic [3:0]     slot_q, slot_d;
  logic           last_q, last_d;
  logic           emit;

  assign idx_s   = idx_q[SW-1:0];
  assign in_idx  = SW'(slot_i);
  assign slot_ok = 32'(slot_i) < 32'(SLOTS);
  assign reg_err = (interval_i == 32'd0) || !slot_ok;
  assign found   = slot_ok && (act_q[in_idx] || inact_q[in_idx]);
  assign {rd_os, rd_ivl, rd_dl} = ram_rdata;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.scan_end = idx_q == CW'(SLOTS);
  assign sts_o.scan_act = act_q[idx_s];
  assign sts_o.scan_hit = rd_dl < time_q;

  assign ram_we    = (ctl_i.do_reg && !reg_err) || (ctl_i.fire_emit && !rd_os);
  assign ram_waddr = ctl_i.do_reg ? in_idx : idx_s;
  assign ram_wdata = ctl_i.do_reg ? {one_shot_i, interval_i, sat_add(time_q, interval_i)}
                                  : {rd_os, rd_ivl, sat_add(time_q, rd_ivl)};

  wtt_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctl_i.scan_rd),
    .raddr_i (idx_s),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    time_d  = time_q;
    act_d   = act_q;
    inact_d = inact_q;
    idx_d   = idx_q;
    kind_d  = kind_q;
    slot_d  = slot_q;
    last_d  = last_q;
    emit    = 1'b0;
    if (ctl_i.do_reg) begin
      emit   = 1'b1;
      slot_d = slot_i;
      last_d = 1'b1;
      if (reg_err) begin
        kind_d = KIND_REG_ERR;
      end else begin
        kind_d          = KIND_REG;
        act_d[in_idx]   = 1'b1;
        inact_d[in_idx] = 1'b0;
      end
    end
    if (ctl_i.do_unreg) begin
      emit   = 1'b1;
      slot_d = slot_i;
      last_d = 1'b1;
      kind_d = found ? KIND_UNREG : KIND_NOT_FOUND;
      if (slot_ok) begin
        act_d[in_idx]   = 1'b0;
        inact_d[in_idx] = 1'b0;
      end
    end
    if (ctl_i.do_tick) begin
      idx_d = '0;
      if (time_q != 32'hFFFF_FFFF) begin
        time_d = time_q + 32'd1;
      end
    end
    if (ctl_i.scan_skip) begin
      idx_d = idx_q + CW'(1);
    end
    if (ctl_i.fire_emit) begin
      emit   = 1'b1;
      kind_d = KIND_FIRED;
      slot_d = 4'(idx_s);
      last_d = 1'b0;
      idx_d  = idx_q + CW'(1);
      if (rd_os) begin
        act_d[idx_s]   = 1'b0;
        inact_d[idx_s] = 1'b1;
      end
    end
    if (ctl_i.done_emit) begin
      emit   = 1'b1;
      kind_d = KIND_DONE;
      slot_d = 4'd0;
      last_d = 1'b1;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      act_q       <= '0;
      inact_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      time_q      <= time_d;
      act_q       <= act_d;
      inact_q     <= inact_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    slot_q <= slot_d;
    last_q <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign event_slot_o = slot_q;
  assign time_now_o   = time_q;
  assign last_o       = last_q;

endmodule
